>>> rtl/pts_pkg.sv
// Package for the priority thread slot scheduler.
// Holds item structs, slot and request codes, and the microcode word format.
// No dependencies.
`timescale 1ns / 1ps

package pts_pkg;

  // Width of slot index fields on the ports
  localparam int SLOT_IDX_W = 6;

  // Request codes
  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_YIELD   = 3'd1;
  localparam logic [2:0] REQ_EXIT    = 3'd2;
  localparam logic [2:0] REQ_START   = 3'd3;
  localparam logic [2:0] REQ_SETPRIO = 3'd4;

  // Status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_NO_OTHER = 3'd2;
  localparam logic [2:0] STS_ERR      = 3'd3;
  localparam logic [2:0] STS_ALL_DONE = 3'd4;

  // Priority codes
  localparam logic [1:0] PRIO_LOW  = 2'd0;
  localparam logic [1:0] PRIO_MED  = 2'd1;
  localparam logic [1:0] PRIO_HIGH = 2'd2;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2
  } slot_state_e;

  // Input item
  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] prio_in;
  } req_t;

  // Result item
  typedef struct packed {
    logic [2:0]            status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  running_valid;
    logic [SLOT_IDX_W-1:0] running_slot;
    logic [1:0]            running_prio;
    logic [1:0]            prior_prio;
  } rsp_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    U_NOP       = 4'd0,
    U_FIND_FREE = 4'd1,
    U_PICK_EXCL = 4'd2,
    U_PICK_ALL  = 4'd3,
    U_CREATE    = 4'd4,
    U_YIELD     = 4'd5,
    U_EXIT      = 4'd6,
    U_START     = 4'd7,
    U_SETP      = 4'd8,
    U_ERR       = 4'd9
  } uop_e;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NONE      = 2'd0,
    COND_NOT_VALID = 2'd1,
    COND_VALID     = 2'd2
  } cond_e;

  // Picker search modes
  typedef enum logic [1:0] {
    PM_FREE = 2'd0,
    PM_EXCL = 2'd1,
    PM_ALL  = 2'd2
  } pick_mode_e;

  // Microcode addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UA_CREATE   = 4'd0;
  localparam logic [UPC_W-1:0] UA_CREATE_C = 4'd1;
  localparam logic [UPC_W-1:0] UA_YIELD    = 4'd2;
  localparam logic [UPC_W-1:0] UA_YIELD_C  = 4'd3;
  localparam logic [UPC_W-1:0] UA_EXIT     = 4'd4;
  localparam logic [UPC_W-1:0] UA_EXIT_C   = 4'd5;
  localparam logic [UPC_W-1:0] UA_START    = 4'd6;
  localparam logic [UPC_W-1:0] UA_START_C  = 4'd7;
  localparam logic [UPC_W-1:0] UA_SETP     = 4'd8;
  localparam logic [UPC_W-1:0] UA_SETP_C   = 4'd9;
  localparam logic [UPC_W-1:0] UA_ERR      = 4'd10;

  // One control word
  typedef struct packed {
    uop_e             uop;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic accept;
    uop_e uop;
  } seq_ctrl_t;

endpackage

>>> rtl/priority_thread_slot_scheduler.sv
// Top level of the priority thread slot scheduler.
// Uses pts_pkg, pts_sequencer and pts_datapath.
`timescale 1ns / 1ps

// Usage:
//   An item (req_i: request code and priority) is taken at a rising edge
//   where start is high and busy is low. Each item gives exactly one result
//   on rsp_o, shown for a single cycle with rsp_valid_o high.
//   Inside, a microcode sequencer runs a two-step program per request: a
//   pick step that searches the slot table (a no-op step for set priority),
//   then a commit step that updates it and loads the result register. Yield,
//   exit, start and set priority without the needed current-thread condition
//   jump from the pick step to an error step, which takes the place of the
//   commit step. An unused request code runs the error step alone.
//   The result strobe comes from a register loaded by the last step. busy
//   drops during the last step, so a new item can be taken while the
//   previous item is still in its last step.
//   Reset clears all slots to free and drops the current thread; nothing is
//   in flight afterwards. The receiver cannot stall: the strobe is not held.
module priority_thread_slot_scheduler #(
  parameter int THREAD_SLOTS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  pts_pkg::req_t req_i,
  output logic          busy,
  output logic          rsp_valid_o,
  output pts_pkg::rsp_t rsp_o
);

  pts_pkg::seq_ctrl_t ctrl;
  logic               cur_valid;

  pts_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_i.req_type),
    .cur_valid_i (cur_valid),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  pts_datapath #(.N(THREAD_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .prio_in_i   (req_i.prio_in),
    .cur_valid_o (cur_valid),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // An accepted item shows its result strobe within the program length
  a_rsp_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##[2:3] rsp_valid_o)
    else $error("no result strobe after an accepted item");

  // No running thread means zeroed running fields
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.running_valid) |->
      (rsp_o.running_slot == '0 && rsp_o.running_prio == '0))
    else $error("running fields set without a running thread");

  // All-finished report leaves no current thread
  a_all_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == pts_pkg::STS_ALL_DONE) |->
      (!rsp_o.running_valid && !cur_valid))
    else $error("current thread still valid after all finished");

endmodule

>>> rtl/pts_ucode_rom.sv
// Microcode ROM of the priority thread slot scheduler.
// One control word per step address. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_ucode_rom (
  input  logic [pts_pkg::UPC_W-1:0] upc_i,
  output pts_pkg::ucode_t           word_o
);

  always_comb begin
    unique case (upc_i)
      // create: find a free slot, then claim it
      pts_pkg::UA_CREATE:   word_o = '{pts_pkg::U_FIND_FREE, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b0};
      pts_pkg::UA_CREATE_C: word_o = '{pts_pkg::U_CREATE, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b1};
      // yield: needs a current thread
      pts_pkg::UA_YIELD:    word_o = '{pts_pkg::U_PICK_EXCL, pts_pkg::COND_NOT_VALID,
                                       pts_pkg::UA_ERR, 1'b0};
      pts_pkg::UA_YIELD_C:  word_o = '{pts_pkg::U_YIELD, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b1};
      // exit: needs a current thread
      pts_pkg::UA_EXIT:     word_o = '{pts_pkg::U_PICK_EXCL, pts_pkg::COND_NOT_VALID,
                                       pts_pkg::UA_ERR, 1'b0};
      pts_pkg::UA_EXIT_C:   word_o = '{pts_pkg::U_EXIT, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b1};
      // start: only with no current thread
      pts_pkg::UA_START:    word_o = '{pts_pkg::U_PICK_ALL, pts_pkg::COND_VALID,
                                       pts_pkg::UA_ERR, 1'b0};
      pts_pkg::UA_START_C:  word_o = '{pts_pkg::U_START, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b1};
      // set priority: needs a current thread
      pts_pkg::UA_SETP:     word_o = '{pts_pkg::U_NOP, pts_pkg::COND_NOT_VALID,
                                       pts_pkg::UA_ERR, 1'b0};
      pts_pkg::UA_SETP_C:   word_o = '{pts_pkg::U_SETP, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b1};
      // error report, also for unused addresses
      default:              word_o = '{pts_pkg::U_ERR, pts_pkg::COND_NONE,
                                       pts_pkg::UA_ERR, 1'b1};
    endcase
  end

endmodule

>>> rtl/pts_sequencer.sv
// Microcode sequencer: step counter, request dispatch and conditional jumps.
// Depends on pts_pkg and pts_ucode_rom.
`timescale 1ns / 1ps

module pts_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            req_type_i,
  input  logic                  cur_valid_i,
  output logic                  busy_o,
  output pts_pkg::seq_ctrl_t    ctrl_o
);

  logic                      busy_q, busy_d;
  logic [pts_pkg::UPC_W-1:0] upc_q, upc_d;
  logic [pts_pkg::UPC_W-1:0] entry;
  pts_pkg::ucode_t           word;
  logic                      take;
  logic                      accept;

  pts_ucode_rom u_rom (
    .upc_i  (upc_q),
    .word_o (word)
  );

  // Entry address per request code
  always_comb begin
    unique case (req_type_i)
      pts_pkg::REQ_CREATE:  entry = pts_pkg::UA_CREATE;
      pts_pkg::REQ_YIELD:   entry = pts_pkg::UA_YIELD;
      pts_pkg::REQ_EXIT:    entry = pts_pkg::UA_EXIT;
      pts_pkg::REQ_START:   entry = pts_pkg::UA_START;
      pts_pkg::REQ_SETPRIO: entry = pts_pkg::UA_SETP;
      default:              entry = pts_pkg::UA_ERR;
    endcase
  end

  // Jump condition
  always_comb begin
    unique case (word.cond)
      pts_pkg::COND_NOT_VALID: take = ~cur_valid_i;
      pts_pkg::COND_VALID:     take = cur_valid_i;
      default:                 take = 1'b0;
    endcase
  end

  // Free for a new item during the last step of the current one
  assign busy_o = busy_q & ~word.last;
  assign accept = start_i & ~busy_o;

  // Step counter
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (busy_q) begin
      if (word.last) begin
        busy_d = 1'b0;
      end else if (take) begin
        upc_d = word.target;
      end else begin
        upc_d = upc_q + 1'b1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      upc_d  = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= pts_pkg::UA_CREATE;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign ctrl_o.accept = accept;
  assign ctrl_o.uop    = busy_q ? word.uop : pts_pkg::U_NOP;

endmodule

>>> rtl/pts_picker.sv
// Slot picker: first free slot, or the best runnable slot by priority then index.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_picker #(
  parameter int N = 4
) (
  input  pts_pkg::slot_state_e [N-1:0]         state_i,
  input  logic [N-1:0][1:0]                    prio_i,
  input  logic [((N > 1) ? $clog2(N) : 1)-1:0] cur_i,
  input  pts_pkg::pick_mode_e                  mode_i,
  output logic                                 found_o,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx_o
);

  localparam int SlotW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] free_v, hi_v, med_v, lo_v, cand, first;
  logic         run;

  // Per-slot candidate flags
  always_comb begin
    for (int i = 0; i < N; i++) begin
      free_v[i] = (state_i[i] == pts_pkg::ST_FREE);
      run       = (state_i[i] == pts_pkg::ST_RUNNABLE) &&
                  !((mode_i == pts_pkg::PM_EXCL) && (SlotW'(i) == cur_i));
      hi_v[i]   = run && (prio_i[i] == pts_pkg::PRIO_HIGH);
      med_v[i]  = run && (prio_i[i] == pts_pkg::PRIO_MED);
      lo_v[i]   = run && (prio_i[i] == pts_pkg::PRIO_LOW);
    end
  end

  // Highest nonempty priority class
  always_comb begin
    priority if (mode_i == pts_pkg::PM_FREE) begin
      cand = free_v;
    end else if (|hi_v) begin
      cand = hi_v;
    end else if (|med_v) begin
      cand = med_v;
    end else begin
      cand = lo_v;
    end
  end

  // Lowest set bit, then encode
  assign first   = cand & (~cand + N'(1));
  assign found_o = |cand;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < N; i++) begin
      idx_o = idx_o | (first[i] ? SlotW'(i) : '0);
    end
  end

endmodule

>>> rtl/pts_datapath.sv
// Scheduler datapath: slot table, current pointer, pick register, result register.
// Depends on pts_pkg and pts_picker.
`timescale 1ns / 1ps

module pts_datapath #(
  parameter int N = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pts_pkg::seq_ctrl_t ctrl_i,
  input  logic [1:0]         prio_in_i,
  output logic               cur_valid_o,
  output logic               rsp_valid_o,
  output pts_pkg::rsp_t      rsp_o
);

  localparam int SlotW = (N > 1) ? $clog2(N) : 1;
  localparam int IdxW  = pts_pkg::SLOT_IDX_W;

  pts_pkg::slot_state_e [N-1:0] state_q, state_d;
  logic [N-1:0][1:0]            prio_q, prio_d;
  logic [SlotW-1:0]             cur_q, cur_d;
  logic                         cur_valid_q, cur_valid_d;
  logic [1:0]                   prio_in_q;
  logic [SlotW-1:0]             pick_q, pick_idx;
  logic                         found_q, pick_found;
  pts_pkg::pick_mode_e          mode;
  logic                         load_pick, load_rsp;
  pts_pkg::rsp_t                rsp_q, rsp_d;
  logic                         rsp_valid_q;

  // Picker mode from micro-op
  always_comb begin
    unique case (ctrl_i.uop)
      pts_pkg::U_FIND_FREE: mode = pts_pkg::PM_FREE;
      pts_pkg::U_PICK_EXCL: mode = pts_pkg::PM_EXCL;
      default:              mode = pts_pkg::PM_ALL;
    endcase
  end

  pts_picker #(.N(N)) u_picker (
    .state_i (state_q),
    .prio_i  (prio_q),
    .cur_i   (cur_q),
    .mode_i  (mode),
    .found_o (pick_found),
    .idx_o   (pick_idx)
  );

  assign load_pick = (ctrl_i.uop == pts_pkg::U_FIND_FREE) ||
                     (ctrl_i.uop == pts_pkg::U_PICK_EXCL) ||
                     (ctrl_i.uop == pts_pkg::U_PICK_ALL);

  // Commit steps update the table and form the result
  always_comb begin
    state_d      = state_q;
    prio_d       = prio_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    load_rsp     = 1'b1;
    rsp_d        = '0;
    rsp_d.status = pts_pkg::STS_ERR;
    unique case (ctrl_i.uop)
      pts_pkg::U_CREATE: begin
        if (found_q) begin
          state_d[pick_q]  = pts_pkg::ST_RUNNABLE;
          prio_d[pick_q]   = prio_in_q;
          rsp_d.status     = pts_pkg::STS_OK;
          rsp_d.slot_index = IdxW'(pick_q);
        end else begin
          rsp_d.status = pts_pkg::STS_FULL;
        end
      end
      pts_pkg::U_YIELD: begin
        if (found_q) begin
          state_d[cur_q]   = pts_pkg::ST_RUNNABLE;
          state_d[pick_q]  = pts_pkg::ST_RUNNING;
          cur_d            = pick_q;
          rsp_d.status     = pts_pkg::STS_OK;
          rsp_d.slot_index = IdxW'(pick_q);
        end else begin
          rsp_d.status = pts_pkg::STS_NO_OTHER;
        end
      end
      pts_pkg::U_EXIT: begin
        state_d[cur_q] = pts_pkg::ST_FREE;
        if (found_q) begin
          state_d[pick_q]  = pts_pkg::ST_RUNNING;
          cur_d            = pick_q;
          rsp_d.status     = pts_pkg::STS_OK;
          rsp_d.slot_index = IdxW'(pick_q);
        end else begin
          cur_d        = '0;
          cur_valid_d  = 1'b0;
          rsp_d.status = pts_pkg::STS_ALL_DONE;
        end
      end
      pts_pkg::U_START: begin
        if (found_q) begin
          state_d[pick_q]  = pts_pkg::ST_RUNNING;
          cur_d            = pick_q;
          cur_valid_d      = 1'b1;
          rsp_d.status     = pts_pkg::STS_OK;
          rsp_d.slot_index = IdxW'(pick_q);
        end
      end
      pts_pkg::U_SETP: begin
        rsp_d.prior_prio = prio_q[cur_q];
        prio_d[cur_q]    = prio_in_q;
        rsp_d.status     = pts_pkg::STS_OK;
      end
      pts_pkg::U_ERR: begin
        rsp_d.status = pts_pkg::STS_ERR;
      end
      default: begin
        load_rsp = 1'b0;
      end
    endcase
    // Running thread after the step
    rsp_d.running_valid = cur_valid_d;
    rsp_d.running_slot  = cur_valid_d ? IdxW'(cur_d) : '0;
    rsp_d.running_prio  = cur_valid_d ? prio_d[cur_d] : '0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        state_q[i] <= pts_pkg::ST_FREE;
      end
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      rsp_valid_q <= load_rsp;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    if (ctrl_i.accept) begin
      // priority code three saturates to high
      prio_in_q <= (prio_in_i > pts_pkg::PRIO_HIGH) ? pts_pkg::PRIO_HIGH : prio_in_i;
    end
    if (load_pick) begin
      pick_q  <= pick_idx;
      found_q <= pick_found;
    end
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign cur_valid_o = cur_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for priority_thread_slot_scheduler.
// Drives scheduler requests, predicts each response from its own slot table,
// and compares. Depends on pts_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_top;

  localparam int THREAD_SLOTS = 4;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 4;

  // Unused request codes and the out-of-range priority code
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
  localparam logic [1:0] PRIO_SAT         = 2'd3;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  pts_pkg::req_t  req_i;
  logic           busy;
  logic           rsp_valid_o;
  pts_pkg::rsp_t  rsp_o;

  // Shadow scheduler state
  pts_pkg::slot_state_e slot_st [THREAD_SLOTS];
  logic [1:0]           slot_pr [THREAD_SLOTS];
  int                   cur_slot;
  bit                   cur_valid;

  pts_pkg::rsp_t sched_rsp_q[$];
  int            n_sent;
  int            n_checked;
  int            n_errors;
  int            n_shown;
  int            status_hits[8];

  priority_thread_slot_scheduler #(.THREAD_SLOTS(THREAD_SLOTS)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Highest priority first, lowest index within a priority
  function automatic int pick_slot(bit skip_cur);
    for (int p = int'(pts_pkg::PRIO_HIGH); p >= int'(pts_pkg::PRIO_LOW); p--) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        if (!(skip_cur && i == cur_slot) && slot_st[i] == pts_pkg::ST_RUNNABLE &&
            int'(slot_pr[i]) == p)
          return i;
      end
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the response it gives
  function automatic pts_pkg::rsp_t schedule_step(pts_pkg::req_t r);
    pts_pkg::rsp_t o;
    logic [1:0]    pr;
    int            pick;
    o        = '0;
    o.status = pts_pkg::STS_ERR;
    pr       = (r.prio_in > pts_pkg::PRIO_HIGH) ? pts_pkg::PRIO_HIGH : r.prio_in;
    case (r.req_type)
      pts_pkg::REQ_CREATE: begin
        o.status = pts_pkg::STS_FULL;
        for (int i = 0; i < THREAD_SLOTS; i++) begin
          if (slot_st[i] == pts_pkg::ST_FREE) begin
            slot_st[i]   = pts_pkg::ST_RUNNABLE;
            slot_pr[i]   = pr;
            o.status     = pts_pkg::STS_OK;
            o.slot_index = pts_pkg::SLOT_IDX_W'(i);
            break;
          end
        end
      end
      pts_pkg::REQ_YIELD: begin
        if (cur_valid) begin
          pick = pick_slot(1'b1);
          if (pick < 0) begin
            o.status = pts_pkg::STS_NO_OTHER;
          end else begin
            slot_st[cur_slot] = pts_pkg::ST_RUNNABLE;
            slot_st[pick]     = pts_pkg::ST_RUNNING;
            cur_slot          = pick;
            o.status          = pts_pkg::STS_OK;
            o.slot_index      = pts_pkg::SLOT_IDX_W'(pick);
          end
        end
      end
      pts_pkg::REQ_EXIT: begin
        if (cur_valid) begin
          pick = pick_slot(1'b1);
          slot_st[cur_slot] = pts_pkg::ST_FREE;
          if (pick < 0) begin
            // last thread gone
            cur_valid = 1'b0;
            cur_slot  = 0;
            o.status  = pts_pkg::STS_ALL_DONE;
          end else begin
            slot_st[pick] = pts_pkg::ST_RUNNING;
            cur_slot      = pick;
            o.status      = pts_pkg::STS_OK;
            o.slot_index  = pts_pkg::SLOT_IDX_W'(pick);
          end
        end
      end
      pts_pkg::REQ_START: begin
        if (!cur_valid) begin
          pick = pick_slot(1'b0);
          if (pick >= 0) begin
            slot_st[pick] = pts_pkg::ST_RUNNING;
            cur_slot      = pick;
            cur_valid     = 1'b1;
            o.status      = pts_pkg::STS_OK;
            o.slot_index  = pts_pkg::SLOT_IDX_W'(pick);
          end
        end
      end
      pts_pkg::REQ_SETPRIO: begin
        if (cur_valid) begin
          o.prior_prio      = slot_pr[cur_slot];
          slot_pr[cur_slot] = pr;
          o.status          = pts_pkg::STS_OK;
        end
      end
      default: begin
      end
    endcase
    o.running_valid = cur_valid;
    if (cur_valid) begin
      o.running_slot = pts_pkg::SLOT_IDX_W'(cur_slot);
      o.running_prio = slot_pr[cur_slot];
    end
    return o;
  endfunction

  // Hold one item on the inputs until it is taken, then log its response.
  // start is left high; the caller either sends again or pauses.
  task automatic send_req(input logic [2:0] code, input logic [1:0] prio);
    pts_pkg::req_t r;
    r.req_type = code;
    r.prio_in  = prio;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sched_rsp_q.push_back(schedule_step(r));
    n_sent++;
  endtask

  task automatic pause_tx(input int n);
    start <= 1'b0;
    repeat ((n < 1) ? 1 : n) @(posedge clk_i);
  endtask

  // Stop sending and wait out every outstanding response
  task automatic drain_rsp();
    pause_tx(1);
    while (sched_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [1:0] any_prio();
    return 2'($urandom_range(0, 3));
  endfunction

  // Requests that need a current thread, start on an empty table, unused codes
  task automatic test_no_thread();
    send_req(pts_pkg::REQ_YIELD, any_prio());
    send_req(pts_pkg::REQ_EXIT, any_prio());
    send_req(pts_pkg::REQ_SETPRIO, any_prio());
    send_req(pts_pkg::REQ_START, any_prio());
    for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
      send_req(3'(c), any_prio());
    drain_rsp();
  endtask

  // Fill the table, overflow it, start, start again while running
  task automatic test_fill_and_start();
    send_req(pts_pkg::REQ_CREATE, pts_pkg::PRIO_LOW);
    send_req(pts_pkg::REQ_CREATE, pts_pkg::PRIO_MED);
    send_req(pts_pkg::REQ_CREATE, PRIO_SAT);
    send_req(pts_pkg::REQ_CREATE, pts_pkg::PRIO_HIGH);
    send_req(pts_pkg::REQ_CREATE, pts_pkg::PRIO_MED);
    send_req(pts_pkg::REQ_START, any_prio());
    send_req(pts_pkg::REQ_START, any_prio());
    drain_rsp();
  endtask

  // Switch around, reprioritize, then exit down to nothing
  task automatic test_switching();
    send_req(pts_pkg::REQ_YIELD, any_prio());
    send_req(pts_pkg::REQ_SETPRIO, pts_pkg::PRIO_LOW);
    send_req(pts_pkg::REQ_YIELD, any_prio());
    send_req(pts_pkg::REQ_EXIT, any_prio());
    send_req(pts_pkg::REQ_SETPRIO, PRIO_SAT);
    send_req(pts_pkg::REQ_EXIT, any_prio());
    send_req(pts_pkg::REQ_EXIT, any_prio());
    send_req(pts_pkg::REQ_YIELD, any_prio());
    send_req(pts_pkg::REQ_EXIT, any_prio());
    send_req(pts_pkg::REQ_YIELD, any_prio());
    drain_rsp();
  endtask

  // Mostly legal traffic that keeps threads alive, with some junk mixed in
  task automatic test_random(input int n_items);
    int         burst_left;
    int         roll;
    logic [2:0] code;
    burst_left = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (!cur_valid && roll < 40)
        code = pts_pkg::REQ_START;
      else if (roll < 30)
        code = pts_pkg::REQ_CREATE;
      else if (roll < 50)
        code = pts_pkg::REQ_YIELD;
      else if (roll < 64)
        code = pts_pkg::REQ_EXIT;
      else if (roll < 72)
        code = pts_pkg::REQ_START;
      else if (roll < 91)
        code = pts_pkg::REQ_SETPRIO;
      else
        code = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      send_req(code, any_prio());
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 19) == 0)
          drain_rsp();
        else
          pause_tx($urandom_range(1, 8));
        // some long bursts so back-to-back traffic gets exercised
        burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      end
    end
    drain_rsp();
  endtask

  // Response checker
  always @(posedge clk_i) begin : chk_rsp
    pts_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      status_hits[rsp_o.status]++;
      if (sched_rsp_q.size() == 0) begin
        n_errors++;
        if (n_shown < MAX_SHOWN) begin
          n_shown++;
          $display("[%0t] unexpected response %p", $time, rsp_o);
        end
      end else begin
        want = sched_rsp_q.pop_front();
        n_checked++;
        if (rsp_o.status !== want.status || rsp_o.slot_index !== want.slot_index ||
            rsp_o.running_valid !== want.running_valid ||
            rsp_o.running_slot !== want.running_slot ||
            rsp_o.running_prio !== want.running_prio ||
            rsp_o.prior_prio !== want.prior_prio) begin
          n_errors++;
          if (n_shown < MAX_SHOWN) begin
            n_shown++;
            $display("[%0t] response %0d mismatch: expected %p, got %p",
                     $time, n_checked, want, rsp_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    req_i     = '0;
    cur_slot  = 0;
    cur_valid = 1'b0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      slot_st[i] = pts_pkg::ST_FREE;
      slot_pr[i] = pts_pkg::PRIO_LOW;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_thread();
    test_fill_and_start();
    test_switching();
    test_random(500);
    test_random(500);

    if (sched_rsp_q.size() != 0) begin
      n_errors += sched_rsp_q.size();
      $display("%0d responses never arrived", sched_rsp_q.size());
    end
    $display("%0d requests issued, %0d responses compared, %0d errors",
             n_sent, n_checked, n_errors);
    $display("status mix: ok %0d, full %0d, no other %0d, error %0d, all done %0d",
             status_hits[pts_pkg::STS_OK], status_hits[pts_pkg::STS_FULL],
             status_hits[pts_pkg::STS_NO_OTHER], status_hits[pts_pkg::STS_ERR],
             status_hits[pts_pkg::STS_ALL_DONE]);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired after %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
